FILE: hw/rtl/crrc_pkg.sv
`timescale 1ns / 1ps

package crrc_pkg;

  localparam int unsigned CNT_W        = 21;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned BOUNCE_BYTES = 1048576;
  localparam int unsigned RING_LOW_RST  = 4096;
  localparam int unsigned RING_HIGH_RST = 262144;

  typedef enum logic {
    OP_RESERVE = 1'b0,
    OP_COMMIT  = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IN_PLACE  = 3'd0,
    ST_BOUNCE    = 3'd1,
    ST_FULL      = 3'd2,
    ST_COMMITTED = 3'd3,
    ST_TOO_LARGE = 3'd4,
    ST_UNALIGNED = 3'd5,
    ST_PENDING   = 3'd6,
    ST_NO_RESV   = 3'd7
  } status_e;

  localparam logic [CFG_IDX_W-1:0] REG_RING_LOW        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RING_HIGH       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVE_CAPABLE = 2'd2;

endpackage

FILE: hw/rtl/crrc_req_if.sv
`timescale 1ns / 1ps

interface crrc_req_if #(
  parameter int unsigned OFFSET_BITS = 23
);
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [crrc_pkg::CNT_W-1:0]   byte_count;
  logic [OFFSET_BITS-1:0]       consumer_stop;

  modport source (output valid, opcode, byte_count, consumer_stop, input ready);
  modport sink   (input valid, opcode, byte_count, consumer_stop, output ready);
endinterface

FILE: hw/rtl/crrc_rsp_if.sv
`timescale 1ns / 1ps

interface crrc_rsp_if #(
  parameter int unsigned OFFSET_BITS = 23
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   status;
  logic [OFFSET_BITS-1:0]       write_offset;
  logic [crrc_pkg::CNT_W-1:0]   reserved_word;
  logic [OFFSET_BITS-1:0]       next_offset;
  logic [crrc_pkg::CNT_W-1:0]   first_chunk;
  logic [crrc_pkg::CNT_W-1:0]   second_chunk;
  logic                         dword_copy;

  modport source (output valid, status, write_offset, reserved_word, next_offset,
                  first_chunk, second_chunk, dword_copy, input ready);
  modport sink   (input valid, status, write_offset, reserved_word, next_offset,
                  first_chunk, second_chunk, dword_copy, output ready);
endinterface

FILE: hw/rtl/crrc_cfg_if.sv
`timescale 1ns / 1ps

interface crrc_cfg_if #(
  parameter int unsigned OFFSET_BITS = 23
);
  logic                             valid;
  logic                             ready;
  logic [crrc_pkg::CFG_IDX_W-1:0]   index;
  logic [OFFSET_BITS-1:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/crrc_slice.sv
`timescale 1ns / 1ps

module crrc_slice #(
  parameter int unsigned W = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [W-1:0] data_o
);

  logic         valid_q, valid_d;
  logic [W-1:0] data_q;
  logic         load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/crrc_core.sv
`timescale 1ns / 1ps

module crrc_core #(
  parameter int unsigned OFFSET_BITS = 23
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [crrc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [OFFSET_BITS-1:0]           cfg_data_i,
  input  logic                             fire_i,
  input  logic                             opcode_i,
  input  logic [crrc_pkg::CNT_W-1:0]       count_i,
  input  logic [OFFSET_BITS-1:0]           stop_i,
  output crrc_pkg::status_e                status_o,
  output logic [OFFSET_BITS-1:0]           write_offset_o,
  output logic [crrc_pkg::CNT_W-1:0]       reserved_word_o,
  output logic [OFFSET_BITS-1:0]           next_offset_o,
  output logic [crrc_pkg::CNT_W-1:0]       first_chunk_o,
  output logic [crrc_pkg::CNT_W-1:0]       second_chunk_o,
  output logic                             dword_copy_o
);
  import crrc_pkg::*;

  localparam int unsigned SW = ((OFFSET_BITS > CNT_W) ? OFFSET_BITS : CNT_W) + 3;

  typedef logic signed [SW-1:0] sval_t;

  logic [OFFSET_BITS-1:0] ring_low_q, ring_high_q;
  logic                   capable_q;
  logic [OFFSET_BITS-1:0] next_q, next_d;
  logic [CNT_W-1:0]       pend_q, pend_d;
  logic                   bounce_q, bounce_d;

  sval_t n, s, lo, hi, bb, span, sum, wrapped, room;
  logic  too_large, unaligned, fits_in_place, fits_bounce;
  logic  [CNT_W-1:0] first;

  assign n  = $signed({{(SW-OFFSET_BITS){1'b0}}, next_q});
  assign s  = $signed({{(SW-OFFSET_BITS){1'b0}}, stop_i});
  assign lo = $signed({{(SW-OFFSET_BITS){1'b0}}, ring_low_q});
  assign hi = $signed({{(SW-OFFSET_BITS){1'b0}}, ring_high_q});
  assign bb = $signed({{(SW-CNT_W){1'b0}}, count_i});

  assign span      = (hi >= lo) ? (hi - lo) : '0;
  assign sum       = n + bb;
  assign too_large = (bb > sval_t'(BOUNCE_BYTES)) || (bb > span);
  assign unaligned = (count_i[1:0] != 2'b00);

  always_comb begin
    if (n >= s) begin
      fits_in_place = (sum < hi) || ((sum == hi) && (s > lo));
      fits_bounce   = !fits_in_place && !(((hi - n) + (s - lo)) <= bb);
    end else begin
      fits_in_place = (sum < s);
      fits_bounce   = 1'b0;
    end
  end

  assign wrapped = (sum >= hi) ? (sum - hi + lo) : sum;
  assign room    = (hi > n) ? (hi - n) : '0;
  assign first   = (bb < room) ? count_i : room[CNT_W-1:0];

  always_comb begin
    next_d          = next_q;
    pend_d          = pend_q;
    bounce_d        = bounce_q;
    status_o        = ST_NO_RESV;
    reserved_word_o = '0;
    first_chunk_o   = '0;
    second_chunk_o  = '0;
    dword_copy_o    = 1'b0;
    if (opcode_i == OP_RESERVE) begin
      priority if (too_large) begin
        status_o = ST_TOO_LARGE;
      end else if (unaligned) begin
        status_o = ST_UNALIGNED;
      end else if (pend_q != '0) begin
        status_o = ST_PENDING;
      end else if (!fits_in_place && !fits_bounce) begin
        status_o = ST_FULL;
      end else if (fits_in_place && (capable_q || (count_i <= CNT_W'(4)))) begin
        status_o        = ST_IN_PLACE;
        bounce_d        = 1'b0;
        pend_d          = count_i;
        reserved_word_o = capable_q ? count_i : '0;
      end else begin
        status_o = ST_BOUNCE;
        bounce_d = 1'b1;
        pend_d   = count_i;
      end
    end else begin
      priority if (pend_q == '0) begin
        status_o = ST_NO_RESV;
      end else if (count_i > pend_q) begin
        status_o = ST_TOO_LARGE;
      end else if (bounce_q && !capable_q && unaligned) begin
        status_o = ST_UNALIGNED;
      end else begin
        status_o = ST_COMMITTED;
        pend_d   = '0;
        next_d   = wrapped[OFFSET_BITS-1:0];
        if (bounce_q) begin
          if (capable_q) begin
            first_chunk_o  = first;
            second_chunk_o = count_i - first;
          end else begin
            dword_copy_o = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_low_q  <= OFFSET_BITS'(RING_LOW_RST);
      ring_high_q <= OFFSET_BITS'(RING_HIGH_RST);
      capable_q   <= 1'b0;
      next_q      <= OFFSET_BITS'(RING_LOW_RST);
      pend_q      <= '0;
      bounce_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_RING_LOW: begin
            ring_low_q <= cfg_data_i;
            next_q     <= cfg_data_i;
          end
          REG_RING_HIGH: begin
            ring_high_q <= cfg_data_i;
          end
          REG_RESERVE_CAPABLE: begin
            capable_q <= cfg_data_i[0];
          end
          default: begin
          end
        endcase
      end else if (fire_i) begin
        next_q   <= next_d;
        pend_q   <= pend_d;
        bounce_q <= bounce_d;
      end
    end
  end

  assign write_offset_o = next_q;
  assign next_offset_o  = next_d;

endmodule

FILE: hw/rtl/command_ring_reserve_commit.sv
`timescale 1ns / 1ps

// Producer-side decision logic for a circular command ring.
// Requests arrive on req_i: a reserve asks for byte_count bytes checked
// against consumer_stop, and a commit advances the next-command offset.
// Every request produces exactly one response beat on rsp_o carrying the
// status, the offsets before and after the request, the reserved register
// value and, for bounce commits, the copy chunk lengths or the dword flag.
// Configuration writes arrive on cfg_i (ring_low, ring_high,
// reserve_capable) and are always taken; they must be issued only while no
// request is in flight. Writing ring_low also reloads the next offset.
// A request beat is registered on acceptance, decided combinationally against
// the ring state, and lands in the response register when that register can
// take it. One request is accepted per cycle as long as rsp_o is drained;
// the state update is made between the two registers and is committed as
// the beat moves into the response register.
// When the receiver stalls, the response register and the input register
// each hold one beat, and req_i.ready drops once both are full.
// Reset restores the register defaults and clears any pending reservation.

module command_ring_reserve_commit #(
  parameter int unsigned OFFSET_BITS = 23
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  crrc_req_if.sink    req_i,
  crrc_rsp_if.source  rsp_o,
  crrc_cfg_if.sink    cfg_i
);
  import crrc_pkg::*;

  typedef struct packed {
    logic                   opcode;
    logic [CNT_W-1:0]       byte_count;
    logic [OFFSET_BITS-1:0] consumer_stop;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic [OFFSET_BITS-1:0] write_offset;
    logic [CNT_W-1:0]       reserved_word;
    logic [OFFSET_BITS-1:0] next_offset;
    logic [CNT_W-1:0]       first_chunk;
    logic [CNT_W-1:0]       second_chunk;
    logic                   dword_copy;
  } rsp_t;

  req_t req_in, req_q;
  rsp_t rsp_d, rsp_q;
  logic req_valid_q, rsp_ready;
  logic fire;

  assign req_in = '{opcode: req_i.opcode, byte_count: req_i.byte_count,
                    consumer_stop: req_i.consumer_stop};

  crrc_slice #(.W($bits(req_t))) u_in_slice (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .ready_o (req_i.ready),
    .data_i  (req_in),
    .valid_o (req_valid_q),
    .ready_i (rsp_ready),
    .data_o  (req_q)
  );

  assign fire        = req_valid_q && rsp_ready;
  assign cfg_i.ready = 1'b1;

  crrc_core #(.OFFSET_BITS(OFFSET_BITS)) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .fire_i          (fire),
    .opcode_i        (req_q.opcode),
    .count_i         (req_q.byte_count),
    .stop_i          (req_q.consumer_stop),
    .status_o        (rsp_d.status),
    .write_offset_o  (rsp_d.write_offset),
    .reserved_word_o (rsp_d.reserved_word),
    .next_offset_o   (rsp_d.next_offset),
    .first_chunk_o   (rsp_d.first_chunk),
    .second_chunk_o  (rsp_d.second_chunk),
    .dword_copy_o    (rsp_d.dword_copy)
  );

  crrc_slice #(.W($bits(rsp_t))) u_out_slice (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_valid_q),
    .ready_o (rsp_ready),
    .data_i  (rsp_d),
    .valid_o (rsp_o.valid),
    .ready_i (rsp_o.ready),
    .data_o  (rsp_q)
  );

  assign rsp_o.status        = rsp_q.status;
  assign rsp_o.write_offset  = rsp_q.write_offset;
  assign rsp_o.reserved_word = rsp_q.reserved_word;
  assign rsp_o.next_offset   = rsp_q.next_offset;
  assign rsp_o.first_chunk   = rsp_q.first_chunk;
  assign rsp_o.second_chunk  = rsp_q.second_chunk;
  assign rsp_o.dword_copy    = rsp_q.dword_copy;

endmodule

FILE: hw/rtl/crrc_checker.sv
`timescale 1ns / 1ps

module crrc_checker #(
  parameter int unsigned OFFSET_BITS = 23
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [2:0]                   status_i,
  input logic [OFFSET_BITS-1:0]       write_offset_i,
  input logic [crrc_pkg::CNT_W-1:0]   reserved_word_i,
  input logic [OFFSET_BITS-1:0]       next_offset_i,
  input logic [crrc_pkg::CNT_W-1:0]   first_chunk_i,
  input logic [crrc_pkg::CNT_W-1:0]   second_chunk_i,
  input logic                         dword_copy_i
);
  import crrc_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i)
      && $stable(next_offset_i))
    else $error("response beat changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != ST_COMMITTED) |->
      (first_chunk_i == '0) && (second_chunk_i == '0) && !dword_copy_i)
    else $error("copy information outside a commit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != ST_IN_PLACE) |-> (reserved_word_i == '0))
    else $error("reserved word set outside an in-place reserve");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != ST_COMMITTED) |-> (next_offset_i == write_offset_i))
    else $error("next offset moved without a commit");

endmodule

bind command_ring_reserve_commit crrc_checker #(.OFFSET_BITS(OFFSET_BITS)) u_crrc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .status_i        (rsp_o.status),
  .write_offset_i  (rsp_o.write_offset),
  .reserved_word_i (rsp_o.reserved_word),
  .next_offset_i   (rsp_o.next_offset),
  .first_chunk_i   (rsp_o.first_chunk),
  .second_chunk_i  (rsp_o.second_chunk),
  .dword_copy_i    (rsp_o.dword_copy)
);
